[rtl/tzcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tzcs_pkg;

    // Input commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CABLE  = 2'd1;
    localparam logic [1:0] CMD_APPLY  = 2'd2;

    // Cable types
    localparam logic [1:0] CABLE_NONE = 2'd0;
    localparam logic [1:0] CABLE_USB  = 2'd1;
    localparam logic [1:0] CABLE_AC   = 2'd2;

    // Thermal zones
    localparam logic [2:0] ZONE_COLD    = 3'd0;
    localparam logic [2:0] ZONE_COOL    = 3'd1;
    localparam logic [2:0] ZONE_NORMAL  = 3'd2;
    localparam logic [2:0] ZONE_WARM    = 3'd3;
    localparam logic [2:0] ZONE_HOT     = 3'd4;
    localparam logic [2:0] ZONE_UNKNOWN = 3'd5;
    localparam int         ZONE_COUNT   = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_CDP_PORT      = 2'd0;
    localparam logic [1:0] CFG_FACTORY_DUMMY = 2'd1;
    localparam logic [1:0] CFG_OFFLINE       = 2'd2;

    // Charger register addresses
    localparam logic [7:0] ADDR_INPUT_LIMIT = 8'h00;
    localparam logic [7:0] ADDR_CHG_CTRL    = 8'h02;
    localparam logic [7:0] ADDR_CMD_A       = 8'h30;
    localparam logic [7:0] ADDR_CMD_B       = 8'h31;

    // Charger register data
    localparam logic [7:0] DATA_CMD_CHG     = 8'h81;
    localparam logic [7:0] DATA_CMD_USB     = 8'h83;
    localparam logic [7:0] DATA_MODE_OFF    = 8'h00;
    localparam logic [7:0] DATA_MODE_HC     = 8'h01;
    localparam logic [7:0] DATA_MODE_500    = 8'h02;
    localparam logic [7:0] DATA_MODE_900    = 8'h06;
    localparam logic [7:0] DATA_LIMIT_1A    = 8'h02;
    localparam logic [7:0] DATA_LIMIT_COOL  = 8'h09;
    localparam logic [7:0] DATA_LIMIT_NORM  = 8'h6A;
    localparam logic [7:0] DATA_CTRL_A      = 8'h8F;
    localparam logic [7:0] DATA_CTRL_B      = 8'h9F;

    localparam logic [11:0] MA_100 = 12'd100;
    localparam logic [11:0] MA_900 = 12'd900;

    // Job queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [2:0] PAIR_LAST_STEP    = 3'd1;
    localparam logic [2:0] CHARGER_LAST_STEP = 3'd6;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_CHARGER = 2'd2
    } t_kind;

    // One classified input: what the back end must emit
    typedef struct packed {
        t_kind      kind;
        logic [7:0] d0;       // pair: data for CMD_A
        logic [7:0] d1;       // pair: data for CMD_B, charger: input limit
        logic [2:0] zone;
        logic       changed;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic signed [12:0] band_lo(input logic [2:0] z);
        case (z)
            3'd0:    return -13'sd2000;
            3'd1:    return -13'sd80;
            3'd2:    return 13'sd20;
            3'd3:    return 13'sd400;
            3'd4:    return 13'sd550;
            default: return 13'sd0;
        endcase
    endfunction

    function automatic logic signed [12:0] band_hi(input logic [2:0] z);
        case (z)
            3'd0:    return -13'sd50;
            3'd1:    return 13'sd50;
            3'd2:    return 13'sd430;
            3'd3:    return 13'sd580;
            3'd4:    return 13'sd2000;
            default: return 13'sd0;
        endcase
    endfunction

    function automatic logic signed [12:0] band_start(input logic [2:0] z);
        case (z)
            3'd0:    return -13'sd2000;
            3'd1:    return -13'sd80;
            3'd2:    return 13'sd20;
            3'd3:    return 13'sd430;
            3'd4:    return 13'sd580;
            default: return 13'sd0;
        endcase
    endfunction

    // Charger sequence step -> {addr, data}
    function automatic logic [15:0] charger_write(input logic [2:0] step,
                                                  input logic [7:0] limit);
        case (step)
            3'd0:    return {ADDR_CMD_A, DATA_CMD_CHG};
            3'd1:    return {ADDR_CMD_B, DATA_MODE_HC};
            3'd2:    return {ADDR_INPUT_LIMIT, limit};
            3'd3:    return {ADDR_CHG_CTRL, DATA_CTRL_A};
            3'd4:    return {ADDR_CHG_CTRL, DATA_CTRL_B};
            3'd5:    return {ADDR_CMD_A, DATA_CMD_USB};
            3'd6:    return {ADDR_CMD_B, DATA_MODE_HC};
            default: return 16'h0000;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/tzcs_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tzcs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [12:0] temperature;
    logic [2:0]         zone_select;
    logic [1:0]         cable_kind;
    logic [11:0]        req_ma;
    logic               cable_present;

    modport source (output valid, command, temperature, zone_select, cable_kind,
                    req_ma, cable_present, input ready);
    modport sink   (input valid, command, temperature, zone_select, cable_kind,
                    req_ma, cable_present, output ready);
endinterface

interface tzcs_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic [2:0] zone;
    logic       zone_changed;
    logic       last;

    modport source (output valid, write_valid, reg_addr, reg_data, zone, zone_changed,
                    last, input ready);
    modport sink   (input valid, write_valid, reg_addr, reg_data, zone, zone_changed,
                    last, output ready);
endinterface

interface tzcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/thermal_zone_charge_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Battery thermal zone tracker and charger register write sequencer.
//
// Channels: i_in carries commands (temperature sample, cable event, apply zone);
// o_out carries result items, each either a charger register write or a status
// item with no write; i_cfg writes the port, factory and offline settings and is
// always ready. Every channel moves a transaction when valid and ready are high.
//
// Each input transaction yields one to seven result transactions; the final one
// has last set, and every one reports the zone held after the input.
// The first result of an input passes through the job queue and then the output
// register before it appears on o_out.
// Throughput: the front end accepts one input per cycle while the four-entry job
// queue has room; the back end emits one result per cycle while the receiver takes
// them, so an input yields one status item, two writes, or seven writes.
//
// Reset (i_rst_n low, synchronous) drops the queue and the output register,
// sets the zone to unknown, forgets the last cable and current, clears settings.
// A stalled receiver holds the output register; the queue then fills and i_in
// ready drops until the back end drains it.
module thermal_zone_charge_sequencer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tzcs_in_if.sink    i_in,
    tzcs_out_if.source o_out,
    tzcs_cfg_if.sink   i_cfg
);

    tzcs_pkg::t_job    push_job;
    tzcs_pkg::t_job    head_job;
    tzcs_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;

    // Front: classify each input, update zone and cable state, queue a job
    tzcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Queue between front and back so each side stalls on its own
    tzcs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_stat     (q_stat)
    );

    // Back: step through the write sequence of the head job
    tzcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // A sequence, once started, streams without gaps while the sink takes it
    a_seq_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("write sequence broken by a gap");

    // A status item always closes its input
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.write_valid |-> o_out.last)
        else $error("status item without last");

    // Zone moves are reported only on a sample's status item
    a_changed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zone_changed |-> !o_out.write_valid && o_out.last)
        else $error("zone_changed on a write item");

    // Reported zone stays within the defined codes
    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.zone <= tzcs_pkg::ZONE_UNKNOWN)
        else $error("zone code out of range");

    // Queue never reports full and empty at once
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

endmodule

`default_nettype wire

[rtl/tzcs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tzcs_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    tzcs_in_if.sink          i_in,
    tzcs_cfg_if.sink         i_cfg,
    input  tzcs_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output tzcs_pkg::t_job   o_job
);

    logic        r_cdp_port;
    logic        r_factory_dummy;
    logic        r_offline;
    logic [2:0]  r_zone_now;
    logic [2:0]  r_zone_before;
    logic [11:0] r_last_current;
    logic [1:0]  r_last_cable;

    logic [2:0]  n_zone_now;
    logic [2:0]  n_zone_before;
    logic [11:0] n_last_current;
    logic [1:0]  n_last_cable;

    logic        samp_found;
    logic [2:0]  samp_idx;
    logic        ignore;
    logic [1:0]  eff_last_cable;
    tzcs_pkg::t_job job;

    // Build the write job for a zone, cable and current
    function automatic tzcs_pkg::t_job zone_job(input logic [2:0]  zone,
                                                input logic [1:0]  cable,
                                                input logic        present,
                                                input logic [11:0] cur,
                                                input logic        cdp,
                                                input logic        offline);
        tzcs_pkg::t_job j;
        logic [7:0]     mode;
        j      = '0;
        j.kind = tzcs_pkg::KIND_STATUS;
        mode   = tzcs_pkg::DATA_MODE_500;
        if (!offline) begin
            if (cur == tzcs_pkg::MA_100) begin
                mode = tzcs_pkg::DATA_MODE_OFF;
            end else if (cur == tzcs_pkg::MA_900) begin
                mode = tzcs_pkg::DATA_MODE_900;
            end
        end
        if (present) begin
            case (zone)
                tzcs_pkg::ZONE_COLD, tzcs_pkg::ZONE_HOT: begin
                    j.kind = tzcs_pkg::KIND_PAIR;
                    j.d0   = tzcs_pkg::DATA_CMD_CHG;
                    j.d1   = tzcs_pkg::DATA_MODE_OFF;
                end
                tzcs_pkg::ZONE_COOL, tzcs_pkg::ZONE_WARM: begin
                    if (cable == tzcs_pkg::CABLE_USB) begin
                        j.kind = tzcs_pkg::KIND_PAIR;
                        j.d0   = tzcs_pkg::DATA_CMD_USB;
                        j.d1   = mode;
                    end else begin
                        j.kind = tzcs_pkg::KIND_CHARGER;
                        j.d1   = cdp ? tzcs_pkg::DATA_LIMIT_1A : tzcs_pkg::DATA_LIMIT_COOL;
                    end
                end
                tzcs_pkg::ZONE_NORMAL: begin
                    if (cable == tzcs_pkg::CABLE_USB) begin
                        j.kind = tzcs_pkg::KIND_PAIR;
                        j.d0   = tzcs_pkg::DATA_CMD_USB;
                        j.d1   = mode;
                    end else begin
                        j.kind = tzcs_pkg::KIND_CHARGER;
                        j.d1   = tzcs_pkg::DATA_LIMIT_NORM;
                    end
                end
                default: j.kind = tzcs_pkg::KIND_STATUS;
            endcase
        end
        return j;
    endfunction

    assign i_in.ready  = !i_q_stat.full;
    assign i_cfg.ready = 1'b1;
    assign o_push      = i_in.valid && i_in.ready;
    assign o_job       = job;

    // Hysteresis search over the five bands
    always_comb begin
        samp_found = 1'b0;
        samp_idx   = r_zone_now;
        if (r_zone_now >= 3'(tzcs_pkg::ZONE_COUNT)) begin
            for (int i = 0; i < tzcs_pkg::ZONE_COUNT; i++) begin
                if (i_in.temperature > tzcs_pkg::band_start(3'(i))) begin
                    samp_found = 1'b1;
                    samp_idx   = 3'(i);
                end
            end
        end else if (i_in.temperature < tzcs_pkg::band_lo(r_zone_now)) begin
            // ascending scan: the last hit is the nearest band below
            for (int i = 0; i < tzcs_pkg::ZONE_COUNT; i++) begin
                if (3'(i) < r_zone_now &&
                    i_in.temperature <  tzcs_pkg::band_hi(3'(i)) &&
                    i_in.temperature >= tzcs_pkg::band_lo(3'(i))) begin
                    samp_found = 1'b1;
                    samp_idx   = 3'(i);
                end
            end
        end else if (i_in.temperature >= tzcs_pkg::band_hi(r_zone_now)) begin
            // descending scan: the last hit is the nearest band above
            for (int i = tzcs_pkg::ZONE_COUNT - 1; i >= 0; i--) begin
                if (3'(i) > r_zone_now &&
                    i_in.temperature <  tzcs_pkg::band_hi(3'(i)) &&
                    i_in.temperature >= tzcs_pkg::band_lo(3'(i))) begin
                    samp_found = 1'b1;
                    samp_idx   = 3'(i);
                end
            end
        end
    end

    always_comb begin
        n_zone_now     = r_zone_now;
        n_zone_before  = r_zone_before;
        n_last_current = r_last_current;
        n_last_cable   = r_last_cable;
        eff_last_cable = i_in.cable_present ? r_last_cable : tzcs_pkg::CABLE_NONE;
        ignore         = (r_last_current == i_in.req_ma) &&
                         ((eff_last_cable == i_in.cable_kind) || !i_in.cable_present);
        job            = '0;
        job.kind       = tzcs_pkg::KIND_STATUS;
        case (i_in.command)
            tzcs_pkg::CMD_SAMPLE: begin
                n_zone_before = r_zone_now;
                if (samp_found) begin
                    n_zone_now = samp_idx;
                end
                job.changed = samp_found;
            end
            tzcs_pkg::CMD_CABLE: begin
                n_last_cable = eff_last_cable;
                if (!ignore) begin
                    n_last_current = i_in.req_ma;
                    n_last_cable   = i_in.cable_kind;
                    if (i_in.cable_kind == tzcs_pkg::CABLE_USB) begin
                        if (r_factory_dummy) begin
                            job.kind = tzcs_pkg::KIND_PAIR;
                            job.d0   = tzcs_pkg::DATA_CMD_USB;
                            job.d1   = tzcs_pkg::DATA_MODE_900;
                        end else begin
                            job = zone_job(r_zone_before, i_in.cable_kind,
                                           i_in.cable_present, i_in.req_ma,
                                           r_cdp_port, r_offline);
                        end
                    end else if (i_in.cable_kind == tzcs_pkg::CABLE_AC) begin
                        job = zone_job(r_zone_before, i_in.cable_kind,
                                       i_in.cable_present, i_in.req_ma,
                                       r_cdp_port, r_offline);
                    end
                end
            end
            tzcs_pkg::CMD_APPLY: begin
                job = zone_job(i_in.zone_select, i_in.cable_kind, i_in.cable_present,
                               r_last_current, r_cdp_port, r_offline);
            end
            default: job.kind = tzcs_pkg::KIND_STATUS;
        endcase
        job.zone = n_zone_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdp_port      <= 1'b0;
            r_factory_dummy <= 1'b0;
            r_offline       <= 1'b0;
            r_zone_now      <= tzcs_pkg::ZONE_UNKNOWN;
            r_zone_before   <= tzcs_pkg::ZONE_UNKNOWN;
            r_last_current  <= '0;
            r_last_cable    <= tzcs_pkg::CABLE_NONE;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tzcs_pkg::CFG_CDP_PORT:      r_cdp_port      <= i_cfg.data;
                    tzcs_pkg::CFG_FACTORY_DUMMY: r_factory_dummy <= i_cfg.data;
                    tzcs_pkg::CFG_OFFLINE:       r_offline       <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_zone_now     <= n_zone_now;
                r_zone_before  <= n_zone_before;
                r_last_current <= n_last_current;
                r_last_cable   <= n_last_cable;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tzcs_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module tzcs_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  tzcs_pkg::t_job     i_push_job,
    input  wire                i_pop,
    output tzcs_pkg::t_job     o_head,
    output tzcs_pkg::t_q_stat  o_stat
);

    tzcs_pkg::t_job               r_slot [tzcs_pkg::FIFO_DEPTH];
    logic [tzcs_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [tzcs_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [tzcs_pkg::FIFO_AW:0]   r_count;

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == (tzcs_pkg::FIFO_AW+1)'(tzcs_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tzcs_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tzcs_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tzcs_pkg::t_job    i_head,
    input  tzcs_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    tzcs_out_if.source        o_out
);

    logic       r_step;
    logic [2:0] r_step_cnt;
    logic       r_out_valid;
    logic       r_write_valid;
    logic [7:0] r_reg_addr;
    logic [7:0] r_reg_data;
    logic [2:0] r_zone;
    logic       r_zone_changed;
    logic       r_last;

    logic        slot_free;
    logic        emit;
    logic        is_last;
    logic        wv;
    logic [15:0] wr;

    assign slot_free = !r_out_valid || o_out.ready;
    assign emit      = !i_q_stat.empty && slot_free;
    assign o_pop     = emit && is_last;

    always_comb begin
        wv      = 1'b0;
        wr      = 16'h0000;
        is_last = 1'b1;
        case (i_head.kind)
            tzcs_pkg::KIND_PAIR: begin
                wv      = 1'b1;
                is_last = (r_step_cnt == tzcs_pkg::PAIR_LAST_STEP);
                wr      = is_last ? {tzcs_pkg::ADDR_CMD_B, i_head.d1}
                                  : {tzcs_pkg::ADDR_CMD_A, i_head.d0};
            end
            tzcs_pkg::KIND_CHARGER: begin
                wv      = 1'b1;
                is_last = (r_step_cnt == tzcs_pkg::CHARGER_LAST_STEP);
                wr      = tzcs_pkg::charger_write(r_step_cnt, i_head.d1);
            end
            default: begin
                wv      = 1'b0;
                is_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_write_valid  <= wv;
            r_reg_addr     <= wr[15:8];
            r_reg_data     <= wr[7:0];
            r_zone         <= i_head.zone;
            r_zone_changed <= i_head.changed && !wv;
            r_last         <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step_cnt  <= '0;
            r_step      <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_step_cnt  <= is_last ? 3'd0 : r_step_cnt + 3'd1;
                r_step      <= !is_last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.write_valid  = r_write_valid;
    assign o_out.reg_addr     = r_reg_addr;
    assign o_out.reg_data     = r_reg_data;
    assign o_out.zone         = r_zone;
    assign o_out.zone_changed = r_zone_changed;
    assign o_out.last         = r_last || !r_step;

endmodule

`default_nettype wire

[tb/thermal_zone_charge_sequencer_tb.sv]
`timescale 1ns / 1ps

module thermal_zone_charge_sequencer_tb;
    import tzcs_pkg::*;

    // Codes the package leaves unnamed but the field widths allow
    localparam logic [1:0] CMD_RESERVED   = 2'd3;
    localparam logic [1:0] CABLE_RESERVED = 2'd3;
    localparam logic [2:0] ZONE_SPARE_LO  = 3'd6;
    localparam logic [2:0] ZONE_SPARE_HI  = 3'd7;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;

    localparam int STALL_LIMIT = 3000;  // quiet cycles before the run is abandoned
    localparam int LONG_HOLD   = 80;    // receiver hold-off that backs up the job queue
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [12:0] temperature;
        logic [2:0]         zone_select;
        logic [1:0]         cable_kind;
        logic [11:0]        req_ma;
        logic               cable_present;
    } t_command;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic [2:0] zone;
        logic       zone_changed;
        logic       last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    tzcs_in_if  in_if ();
    tzcs_out_if out_if ();
    tzcs_cfg_if cfg_if ();

    thermal_zone_charge_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the block: zone tracker, latched cable event, settings
    logic [2:0]  zone_held;
    logic [2:0]  zone_prior;
    logic [11:0] latched_ma;
    logic [1:0]  latched_cable;
    logic        cdp_on;
    logic        factory_on;
    logic        offline_on;

    t_command commands_to_send[$];
    t_result  writes_due[$];
    t_result  write_burst[$];     // writes planned for the transaction being predicted

    t_command next_cmd;
    t_result  want;
    bit       in_taken;
    int       inputs_accepted;
    int       fault_count;
    int       quiet_cycles;
    int       send_gap;
    int       recv_gap;
    int       hold_left;
    int       holds_done;
    bit       sender_restless;
    bit       receiver_restless;
    bit       calm_finish;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Band edges in tenths of a degree: lower bound, upper bound (exclusive)
    // and the entry point used when leaving the unknown zone.
    function automatic void band_edges(input int z, output int lo, output int hi,
                                       output int entry);
        case (z)
            0:       begin lo = -2000; hi = -50;  entry = -2000; end
            1:       begin lo = -80;   hi = 50;   entry = -80;   end
            2:       begin lo = 20;    hi = 430;  entry = 20;    end
            3:       begin lo = 400;   hi = 580;  entry = 430;   end
            default: begin lo = 550;   hi = 2000; entry = 580;   end
        endcase
    endfunction

    // Move the tracked zone for one sample; return 1 when it moved.
    function automatic logic track_zone(input int t);
        int s;
        int k;
        int idx;
        int lo;
        int hi;
        int entry;
        s = zone_held;
        zone_prior = zone_held;
        if (s >= ZONE_COUNT) begin
            // From unknown: the highest band whose entry point lies below t
            idx = -1;
            for (k = ZONE_COUNT - 1; k >= 0; k--) begin
                band_edges(k, lo, hi, entry);
                if (idx < 0 && t > entry) idx = k;
            end
        end else begin
            band_edges(s, lo, hi, entry);
            if (t < lo) begin
                idx = -1;
                for (k = s - 1; k >= 0; k--) begin
                    band_edges(k, lo, hi, entry);
                    if (idx < 0 && t < hi && t >= lo) idx = k;
                end
            end else if (t >= hi) begin
                idx = ZONE_COUNT;
                for (k = s + 1; k < ZONE_COUNT; k++) begin
                    band_edges(k, lo, hi, entry);
                    if (idx == ZONE_COUNT && t < hi && t >= lo) idx = k;
                end
            end else begin
                return 1'b0;
            end
        end
        if (idx < 0 || idx >= ZONE_COUNT) return 1'b0;
        zone_held = 3'(idx);
        return 1'b1;
    endfunction

    function automatic void plan_write(input logic [7:0] addr, input logic [7:0] data);
        t_result r;
        if (write_burst.size() >= 7) return;
        r = '0;
        r.write_valid = 1'b1;
        r.reg_addr    = addr;
        r.reg_data    = data;
        write_burst.push_back(r);
    endfunction

    function automatic void plan_usb_mode();
        logic [7:0] mode;
        mode = DATA_MODE_500;
        if (!offline_on) begin
            if (latched_ma == MA_100) mode = DATA_MODE_OFF;
            else if (latched_ma == MA_900) mode = DATA_MODE_900;
        end
        plan_write(ADDR_CMD_A, DATA_CMD_USB);
        plan_write(ADDR_CMD_B, mode);
    endfunction

    function automatic void plan_charger(input logic [7:0] input_limit);
        plan_write(ADDR_CMD_A, DATA_CMD_CHG);
        plan_write(ADDR_CMD_B, DATA_MODE_HC);
        plan_write(ADDR_INPUT_LIMIT, input_limit);
        plan_write(ADDR_CHG_CTRL, DATA_CTRL_A);
        plan_write(ADDR_CHG_CTRL, DATA_CTRL_B);
        plan_write(ADDR_CMD_A, DATA_CMD_USB);
        plan_write(ADDR_CMD_B, DATA_MODE_HC);
    endfunction

    function automatic void plan_zone(input logic [2:0] z, input logic [1:0] cable,
                                      input logic present);
        if (!present) return;
        case (z)
            ZONE_COLD, ZONE_HOT: begin
                plan_write(ADDR_CMD_A, DATA_CMD_CHG);
                plan_write(ADDR_CMD_B, DATA_MODE_OFF);
            end
            ZONE_COOL, ZONE_WARM: begin
                if (cable == CABLE_USB) plan_usb_mode();
                else plan_charger(cdp_on ? DATA_LIMIT_1A : DATA_LIMIT_COOL);
            end
            ZONE_NORMAL: begin
                if (cable == CABLE_USB) plan_usb_mode();
                else plan_charger(DATA_LIMIT_NORM);
            end
            default: ;
        endcase
    endfunction

    // Work out every result transaction one command causes and queue them.
    function automatic void predict_writes(input t_command c);
        logic    moved;
        t_result r;
        int      k;
        moved = 1'b0;
        write_burst.delete();
        case (c.command)
            CMD_SAMPLE: moved = track_zone(int'($signed(c.temperature)));
            CMD_CABLE: begin
                if (!c.cable_present) latched_cable = CABLE_NONE;
                if (!(latched_ma == c.req_ma &&
                      (latched_cable == c.cable_kind || !c.cable_present))) begin
                    latched_ma    = c.req_ma;
                    latched_cable = c.cable_kind;
                    if (c.cable_kind == CABLE_USB) begin
                        if (factory_on) begin
                            plan_write(ADDR_CMD_A, DATA_CMD_USB);
                            plan_write(ADDR_CMD_B, DATA_MODE_900);
                        end else begin
                            plan_zone(zone_prior, c.cable_kind, c.cable_present);
                        end
                    end else if (c.cable_kind == CABLE_AC) begin
                        plan_zone(zone_prior, c.cable_kind, c.cable_present);
                    end
                end
            end
            CMD_APPLY: plan_zone(c.zone_select, c.cable_kind, c.cable_present);
            default: ;
        endcase
        if (write_burst.size() == 0) begin
            // No write: a lone status transaction still reports the zone
            r = '0;
            r.zone_changed = moved;
            write_burst.push_back(r);
        end
        for (k = 0; k < write_burst.size(); k++) begin
            r      = write_burst[k];
            r.zone = zone_held;
            r.last = (k == write_burst.size() - 1);
            writes_due.push_back(r);
        end
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    // Start from random noise in every field so unused bits still toggle.
    function automatic t_command noisy_command();
        t_command c;
        c.command       = 2'($urandom);
        c.temperature   = 13'($urandom);
        c.zone_select   = 3'($urandom);
        c.cable_kind    = 2'($urandom);
        c.req_ma        = 12'($urandom);
        c.cable_present = 1'($urandom);
        return c;
    endfunction

    function automatic t_command sample_cmd(input int t);
        t_command c;
        c             = noisy_command();
        c.command     = CMD_SAMPLE;
        c.temperature = 13'(t);
        return c;
    endfunction

    function automatic t_command cable_cmd(input logic [1:0] cable, input int ma,
                                           input logic present);
        t_command c;
        c               = noisy_command();
        c.command       = CMD_CABLE;
        c.cable_kind    = cable;
        c.req_ma        = 12'(ma);
        c.cable_present = present;
        return c;
    endfunction

    function automatic t_command apply_cmd(input logic [2:0] z, input logic [1:0] cable,
                                           input logic present);
        t_command c;
        c               = noisy_command();
        c.command       = CMD_APPLY;
        c.zone_select   = z;
        c.cable_kind    = cable;
        c.cable_present = present;
        return c;
    endfunction

    // Cluster temperatures around band edges, with some full-range values.
    function automatic int pick_temperature();
        int edge_t;
        case ($urandom_range(0, 9))
            0:       edge_t = -2000;
            1:       edge_t = -80;
            2:       edge_t = -50;
            3:       edge_t = 20;
            4:       edge_t = 50;
            5:       edge_t = 400;
            6:       edge_t = 430;
            7:       edge_t = 550;
            8:       edge_t = 580;
            default: edge_t = 2000;
        endcase
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 8191) - 4096;
            1, 2, 3: return edge_t + $urandom_range(0, 4) - 2;
            default: return $urandom_range(0, 1100) - 300;
        endcase
    endfunction

    function automatic int pick_current();
        case ($urandom_range(0, 4))
            0:       return MA_100;
            1:       return MA_900;
            2:       return 500;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       pick;
        c    = noisy_command();
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            c = sample_cmd(pick_temperature());
        end else if (pick < 75) begin
            if ($urandom_range(0, 9) < 8)
                c = cable_cmd($urandom_range(0, 1) ? CABLE_USB : CABLE_AC, pick_current(),
                              $urandom_range(0, 7) != 0);
            else
                c = cable_cmd($urandom_range(0, 1) ? CABLE_NONE : CABLE_RESERVED,
                              pick_current(), 1'($urandom));
        end else if (pick < 95) begin
            c = apply_cmd(3'($urandom_range(0, 7)), 2'($urandom),
                          $urandom_range(0, 7) != 0);
        end else begin
            c.command = CMD_RESERVED;
        end
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Sequencing helpers for the main flow
    // ---------------------------------------------------------------

    // Hold until every command is sent and every result has come back,
    // then let the pipeline settle.
    task automatic wait_for_drain();
        while (commands_to_send.size() != 0 || in_if.valid || writes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [1:0] idx, input logic value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) commands_to_send.push_back(random_command());
    endtask

    // ---------------------------------------------------------------
    // Main flow: reset, directed cases, then random phases per setting
    // ---------------------------------------------------------------
    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.command        = CMD_SAMPLE;
        in_if.temperature    = '0;
        in_if.zone_select    = ZONE_COLD;
        in_if.cable_kind     = CABLE_NONE;
        in_if.req_ma         = '0;
        in_if.cable_present  = 1'b0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_CDP_PORT;
        cfg_if.data          = 1'b0;

        zone_held     = ZONE_UNKNOWN;
        zone_prior    = ZONE_UNKNOWN;
        latched_ma    = '0;
        latched_cable = CABLE_NONE;
        cdp_on        = 1'b0;
        factory_on    = 1'b0;
        offline_on    = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: leaving unknown, hysteresis, stale zone on cable events,
        // repeat filtering, absent cable, reserved codes, every zone sequence.
        commands_to_send.push_back(sample_cmd(-4096));          // stays unknown
        commands_to_send.push_back(sample_cmd(-2000));          // at edge, still unknown
        commands_to_send.push_back(cable_cmd(CABLE_USB, 500, 1'b1));
        commands_to_send.push_back(sample_cmd(4095));           // unknown -> hot
        commands_to_send.push_back(sample_cmd(4095));           // beyond every band
        commands_to_send.push_back(sample_cmd(25));             // hot -> normal
        commands_to_send.push_back(cable_cmd(CABLE_AC, 0, 1'b1));   // uses hot
        commands_to_send.push_back(sample_cmd(25));
        commands_to_send.push_back(cable_cmd(CABLE_USB, 100, 1'b1));
        commands_to_send.push_back(cable_cmd(CABLE_USB, 100, 1'b1)); // repeat, ignored
        commands_to_send.push_back(cable_cmd(CABLE_AC, 100, 1'b0));  // absent, ignored
        commands_to_send.push_back(cable_cmd(CABLE_AC, 900, 1'b0));  // absent, latched
        commands_to_send.push_back(cable_cmd(CABLE_USB, 900, 1'b1));
        commands_to_send.push_back(cable_cmd(CABLE_RESERVED, 4095, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_NORMAL, CABLE_NONE, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_COOL, CABLE_USB, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_WARM, CABLE_RESERVED, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_UNKNOWN, CABLE_AC, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_SPARE_LO, CABLE_AC, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_SPARE_HI, CABLE_USB, 1'b1));
        commands_to_send.push_back(apply_cmd(ZONE_COLD, CABLE_AC, 1'b0));
        commands_to_send.push_back(apply_cmd(ZONE_HOT, CABLE_USB, 1'b1));
        next_cmd         = noisy_command();
        next_cmd.command = CMD_RESERVED;
        commands_to_send.push_back(next_cmd);
        commands_to_send.push_back(sample_cmd(-100));           // normal -> cold
        commands_to_send.push_back(sample_cmd(0));              // cold -> cool
        commands_to_send.push_back(sample_cmd(-4096));          // below every band
        wait_for_drain();

        write_setting(CFG_CDP_PORT, 1'b1);
        queue_random(55);
        wait_for_drain();

        write_setting(CFG_CDP_PORT, 1'b0);
        write_setting(CFG_FACTORY_DUMMY, 1'b1);
        write_setting(CFG_OFFLINE, 1'b1);
        queue_random(55);
        wait_for_drain();

        write_setting(CFG_CDP_PORT, 1'b1);
        write_setting(CFG_FACTORY_DUMMY, 1'b0);
        queue_random(55);
        wait_for_drain();

        write_setting(CFG_UNUSED, 1'b1);
        write_setting(CFG_CDP_PORT, 1'b0);
        write_setting(CFG_OFFLINE, 1'b0);
        queue_random(55);
        wait_for_drain();

        write_setting(CFG_CDP_PORT, 1'b1);
        write_setting(CFG_FACTORY_DUMMY, 1'b1);
        write_setting(CFG_OFFLINE, 1'b1);
        queue_random(55);
        wait_for_drain();

        // Final stretch runs back to back with no idling on either side
        write_setting(CFG_FACTORY_DUMMY, 1'b0);
        write_setting(CFG_OFFLINE, 1'b0);
        calm_finish = 1'b1;
        queue_random(55);
        wait_for_drain();
        repeat (8) @(posedge i_clk);

        if (fault_count == 0)
            $display("thermal_zone_charge_sequencer: match");
        else
            $display("thermal_zone_charge_sequencer: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: offer queued commands at the falling edge, with random gaps
    // between transactions; never drop valid while a command is pending.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if ($urandom_range(0, 49) == 0) sender_restless = ~sender_restless;
        if (!in_if.valid || in_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (sender_restless && !calm_finish && hold_left == 0 &&
                         $urandom_range(0, 5) == 0) begin
                send_gap    = $urandom_range(1, 17) - 1;
                in_if.valid <= 1'b0;
            end else if (commands_to_send.size() != 0) begin
                next_cmd            = commands_to_send.pop_front();
                in_if.valid         <= 1'b1;
                in_if.command       <= next_cmd.command;
                in_if.temperature   <= next_cmd.temperature;
                in_if.zone_select   <= next_cmd.zone_select;
                in_if.cable_kind    <= next_cmd.cable_kind;
                in_if.req_ma        <= next_cmd.req_ma;
                in_if.cable_present <= next_cmd.cable_present;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random ready bursts, plus two long hold-offs that let the
    // job queue fill so the block must stall its input.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if ($urandom_range(0, 49) == 0) receiver_restless = ~receiver_restless;
        if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (holds_done < 2 && inputs_accepted >= 60 + 160 * holds_done) begin
            holds_done++;
            hold_left    = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            out_if.ready <= 1'b0;
        end else if (receiver_restless && !calm_finish && $urandom_range(0, 7) == 0) begin
            recv_gap     = $urandom_range(1, 17) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: at the rising edge, check results against the oldest
    // expectation first, then predict for the command accepted now.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (writes_due.size() == 0) begin
                    note_fault($sformatf({"unexpected result: wv=%0b addr=%02h data=%02h ",
                                          "zone=%0d chg=%0b last=%0b"},
                                         out_if.write_valid, out_if.reg_addr,
                                         out_if.reg_data, out_if.zone,
                                         out_if.zone_changed, out_if.last));
                end else begin
                    want = writes_due.pop_front();
                    if (out_if.write_valid !== want.write_valid ||
                        out_if.reg_addr !== want.reg_addr ||
                        out_if.reg_data !== want.reg_data ||
                        out_if.zone !== want.zone ||
                        out_if.zone_changed !== want.zone_changed ||
                        out_if.last !== want.last)
                        note_fault($sformatf({"result after %0d commands: expected wv=%0b ",
                                              "addr=%02h data=%02h zone=%0d chg=%0b last=%0b",
                                              ", got wv=%0b addr=%02h data=%02h zone=%0d ",
                                              "chg=%0b last=%0b"},
                                             inputs_accepted, want.write_valid,
                                             want.reg_addr, want.reg_data, want.zone,
                                             want.zone_changed, want.last,
                                             out_if.write_valid, out_if.reg_addr,
                                             out_if.reg_data, out_if.zone,
                                             out_if.zone_changed, out_if.last));
                end
            end
            if (in_if.valid && in_if.ready) begin
                in_taken = 1'b1;
                inputs_accepted++;
                next_cmd.command       = in_if.command;
                next_cmd.temperature   = in_if.temperature;
                next_cmd.zone_select   = in_if.zone_select;
                next_cmd.cable_kind    = in_if.cable_kind;
                next_cmd.req_ma        = in_if.req_ma;
                next_cmd.cable_present = in_if.cable_present;
                predict_writes(next_cmd);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_CDP_PORT:      cdp_on     = cfg_if.data;
                    CFG_FACTORY_DUMMY: factory_on = cfg_if.data;
                    CFG_OFFLINE:       offline_on = cfg_if.data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: abandon the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("thermal_zone_charge_sequencer: mismatch");
            $finish;
        end
    end

endmodule
